/* rtl/assert_macros.svh */
// Assertion macros used by the RTL top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that cons holds in the cycle after ante
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

// check that expr never holds
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("assertion failed");

// check that cons holds in the same cycle as ante
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/tfpi_pkg.sv */
// Types and constants of the triangle fan point insert block
`timescale 1ns / 1ps
package tfpi_pkg;
  localparam int MAX_TRI    = 256;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_TRI);
  localparam int CNT_W      = $clog2(MAX_TRI + 1);
  localparam int STEP_W     = $clog2(MAX_TRI + 3);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int FIELD_W    = 16;
  localparam int HIT_W      = 8;
  localparam int COUNT_W    = 9;
  localparam int RIDX_W     = 8;

  localparam logic [1:0] FN_RESTART = 2'd0;
  localparam logic [1:0] FN_INSERT  = 2'd1;
  localparam logic [1:0] FN_READ    = 2'd2;
  localparam logic [1:0] FN_NONE    = 2'd3;

  localparam logic [2:0] REG_SEED_AX = 3'd0;
  localparam logic [2:0] REG_SEED_AY = 3'd1;
  localparam logic [2:0] REG_SEED_BX = 3'd2;
  localparam logic [2:0] REG_SEED_BY = 3'd3;
  localparam logic [2:0] REG_SEED_CX = 3'd4;
  localparam logic [2:0] REG_SEED_CY = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_WRITE, ST_READ, ST_DONE
  } state_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } point_t;

  typedef struct packed {
    point_t c;
    point_t b;
    point_t a;
  } tri_t;

  // one triangle moving through the containment test
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    tri_t             ent;
  } probe_t;
endpackage

/* rtl/triangle_fan_point_insert_top.sv */
// Top level: triangle ring, containment test, sequencer and result register
// Restart and func 3 go straight to the result; read passes the ring once;
// insert scans the ring once, and passes it once more to write when it splits.
// The ring of MAX_TRI cells turns once per pass, one entry per cycle past the test.
// One item at a time; the next is taken once the result is in the output register.
// Reset clears count, sequencer and seed registers; ring contents stay undefined.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module triangle_fan_point_insert_top import tfpi_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // point_x, point_y, read_index
  input  logic [1:0]   s_axis_tuser,  // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata   // inserted, table_full, hit_index, triangle_count,
                                      // out_ax, out_ay, out_bx, out_by, out_cx, out_cy
);
  state_e               state_q, state_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [CNT_W-1:0]     cnt_q;
  logic [FIELD_W-1:0]   seed_q [6];
  point_t               pt_q;
  logic [RIDX_W-1:0]    ridx_q;
  logic                 found_q;
  logic [IDX_W-1:0]     hit_q;
  tri_t                 hent_q;
  logic                 ins_q, full_q;
  tri_t                 rd_q;
  logic                 m_valid_q;
  logic [119:0]         m_data_q;

  tri_t                 ring_q [MAX_TRI];
  tri_t                 tail_d, head_d, wr_val;
  logic                 shift_en, restart, wr_en, in_acc, out_free, room;
  probe_t               probe, hit;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign restart       = in_acc && (s_axis_tuser == FN_RESTART);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign room          = (32'(cnt_q) + 32'd2) <= MAX_TRI;

  assign shift_en = (state_q == ST_SCAN && 32'(step_q) < MAX_TRI) ||
                    state_q == ST_WRITE || state_q == ST_READ;

  // split results re-enter the ring at the tail as the head wraps
  always_comb begin
    wr_en  = 1'b0;
    wr_val = ring_q[0];
    if (state_q == ST_WRITE) begin
      if (32'(step_q) == 32'(hit_q)) begin
        wr_en  = 1'b1;
        wr_val = '{c: pt_q, b: hent_q.b, a: hent_q.a};
      end else if (32'(step_q) == 32'(cnt_q)) begin
        wr_en  = 1'b1;
        wr_val = '{c: pt_q, b: hent_q.c, a: hent_q.b};
      end else if (32'(step_q) == 32'(cnt_q) + 32'd1) begin
        wr_en  = 1'b1;
        wr_val = '{c: pt_q, b: hent_q.a, a: hent_q.c};
      end
    end
    tail_d = wr_en ? wr_val : ring_q[0];
    head_d = ring_q[1];
    if (restart) begin
      head_d.a = '{y: COORD_BITS'(seed_q[1]), x: COORD_BITS'(seed_q[0])};
      head_d.b = '{y: COORD_BITS'(seed_q[3]), x: COORD_BITS'(seed_q[2])};
      head_d.c = '{y: COORD_BITS'(seed_q[5]), x: COORD_BITS'(seed_q[4])};
    end
  end

  for (genvar k = 0; k < MAX_TRI; k++) begin : g_ring
    if (k == 0) begin : g_head
      tfpi_cell u_cell (.clk_i(clk_i), .en_i(shift_en || restart), .d_i(head_d),
                        .q_o(ring_q[k]));
    end else if (k == MAX_TRI - 1) begin : g_tail
      tfpi_cell u_cell (.clk_i(clk_i), .en_i(shift_en), .d_i(tail_d), .q_o(ring_q[k]));
    end else begin : g_mid
      tfpi_cell u_cell (.clk_i(clk_i), .en_i(shift_en), .d_i(ring_q[k+1]),
                        .q_o(ring_q[k]));
    end
  end

  assign probe.valid = state_q == ST_SCAN && 32'(step_q) < MAX_TRI &&
                       32'(step_q) < 32'(cnt_q);
  assign probe.idx   = IDX_W'(step_q);
  assign probe.ent   = ring_q[0];

  tfpi_test u_test (.clk_i(clk_i), .rst_ni(rst_ni), .probe_i(probe), .pt_i(pt_q),
                    .hit_o(hit));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q + STEP_W'(1);
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_acc) begin
          unique case (s_axis_tuser)
            FN_INSERT: state_d = ST_SCAN;
            FN_READ:   state_d = ST_READ;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (32'(step_q) == MAX_TRI + 2) begin
          step_d  = '0;
          state_d = (found_q && room) ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE, ST_READ: begin
        if (32'(step_q) == MAX_TRI - 1) begin
          step_d  = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        step_d = '0;
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      found_q   <= 1'b0;
      ins_q     <= 1'b0;
      full_q    <= 1'b0;
      m_valid_q <= 1'b0;
      for (int r = 0; r < 6; r++) begin
        seed_q[r] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_SEED_AX: seed_q[0] <= cfg_data_i;
          REG_SEED_AY: seed_q[1] <= cfg_data_i;
          REG_SEED_BX: seed_q[2] <= cfg_data_i;
          REG_SEED_BY: seed_q[3] <= cfg_data_i;
          REG_SEED_CX: seed_q[4] <= cfg_data_i;
          REG_SEED_CY: seed_q[5] <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        found_q <= 1'b0;
        ins_q   <= 1'b0;
        full_q  <= 1'b0;
        if (restart) begin
          cnt_q <= CNT_W'(1);
        end
      end
      if (state_q == ST_SCAN) begin
        // keep only the first containing entry
        if (hit.valid && !found_q) begin
          found_q <= 1'b1;
        end
        if (32'(step_q) == MAX_TRI + 2 && found_q && !room) begin
          full_q <= 1'b1;
        end
      end
      if (state_q == ST_WRITE && 32'(step_q) == MAX_TRI - 1) begin
        cnt_q <= cnt_q + CNT_W'(2);
        ins_q <= 1'b1;
      end
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pt_q   <= '{y: COORD_BITS'(s_axis_tdata[31:16]), x: COORD_BITS'(s_axis_tdata[15:0])};
      ridx_q <= s_axis_tdata[39:32];
      rd_q   <= '0;
    end
    if (state_q == ST_SCAN && hit.valid && !found_q) begin
      hit_q  <= hit.idx;
      hent_q <= hit.ent;
    end
    if (state_q == ST_READ && 32'(step_q) == 32'(ridx_q) &&
        32'(ridx_q) < 32'(cnt_q)) begin
      rd_q <= ring_q[0];
    end
    if (state_q == ST_DONE && out_free) begin
      m_data_q <= {5'd0,
                   FIELD_W'(rd_q.c.y), FIELD_W'(rd_q.c.x),
                   FIELD_W'(rd_q.b.y), FIELD_W'(rd_q.b.x),
                   FIELD_W'(rd_q.a.y), FIELD_W'(rd_q.a.x),
                   COUNT_W'(cnt_q),
                   ins_q ? HIT_W'(hit_q) : HIT_W'(0),
                   full_q, ins_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `ASSERT_NEVER(a_count_bound, 32'(cnt_q) > MAX_TRI)
  `ASSERT_NEVER(a_flags_excl, m_valid_q && m_data_q[0] && m_data_q[1])
  `ASSERT_SAME(a_hit_in_range, state_q == ST_SCAN && hit.valid, 32'(hit.idx) < 32'(cnt_q))
  `ASSERT_NEXT(a_split_grows, state_q == ST_WRITE && state_d == ST_DONE,
               cnt_q == $past(cnt_q) + CNT_W'(2))
endmodule

/* rtl/tfpi_cell.sv */
// One cell of the triangle ring: holds one entry, takes its neighbor's on shift
`timescale 1ns / 1ps
module tfpi_cell import tfpi_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  tri_t d_i,
  output tri_t q_o
);
  tri_t tri_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tri_q <= d_i;
    end
  end

  assign q_o = tri_q;
endmodule

/* rtl/tfpi_test.sv */
// Two-stage containment test: cross products, then same-side sign checks
`timescale 1ns / 1ps
module tfpi_test import tfpi_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  probe_t probe_i,
  input  point_t pt_i,
  output probe_t hit_o
);
  logic signed [PROD_W-1:0] prod_d [3][4];
  logic signed [PROD_W-1:0] prod_q [3][4];
  logic                     v1_q;
  logic [IDX_W-1:0]         idx1_q;
  tri_t                     tri1_q;
  logic                     v2_q;
  logic [IDX_W-1:0]         idx2_q;
  tri_t                     tri2_q;
  logic                     contained;

  always_comb begin
    point_t e1 [3];
    point_t e2 [3];
    point_t rf [3];
    logic signed [DIFF_W-1:0] dx, dy, rx, ry, qx, qy;
    e1[0] = probe_i.ent.a; e2[0] = probe_i.ent.b; rf[0] = probe_i.ent.c;
    e1[1] = probe_i.ent.c; e2[1] = probe_i.ent.b; rf[1] = probe_i.ent.a;
    e1[2] = probe_i.ent.c; e2[2] = probe_i.ent.a; rf[2] = probe_i.ent.b;
    for (int e = 0; e < 3; e++) begin
      dx = $signed({1'b0, e2[e].x}) - $signed({1'b0, e1[e].x});
      dy = $signed({1'b0, e2[e].y}) - $signed({1'b0, e1[e].y});
      rx = $signed({1'b0, rf[e].x}) - $signed({1'b0, e1[e].x});
      ry = $signed({1'b0, rf[e].y}) - $signed({1'b0, e1[e].y});
      qx = $signed({1'b0, pt_i.x}) - $signed({1'b0, e1[e].x});
      qy = $signed({1'b0, pt_i.y}) - $signed({1'b0, e1[e].y});
      prod_d[e][0] = dx * ry;
      prod_d[e][1] = dy * rx;
      prod_d[e][2] = dx * qy;
      prod_d[e][3] = dy * qx;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    idx1_q <= probe_i.idx;
    tri1_q <= probe_i.ent;
  end

  // fail only where reference and point sit strictly on opposite sides
  always_comb begin
    contained = 1'b1;
    for (int e = 0; e < 3; e++) begin
      if ((prod_q[e][0] > prod_q[e][1] && prod_q[e][2] < prod_q[e][3]) ||
          (prod_q[e][0] < prod_q[e][1] && prod_q[e][2] > prod_q[e][3])) begin
        contained = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= probe_i.valid;
      v2_q <= v1_q && contained;
    end
  end

  always_ff @(posedge clk_i) begin
    idx2_q <= idx1_q;
    tri2_q <= tri1_q;
  end

  assign hit_o = '{valid: v2_q, idx: idx2_q, ent: tri2_q};
endmodule
